### rtl/core/ppcg_pkg.sv
// Shared constants for the plasma pixel color generator: register map, resets, sine table.
package ppcg_pkg;

  localparam int unsigned CfgAddrWidth = 3;
  localparam int unsigned CfgDataWidth = 32;

  // register index, taken from paddr bit 2
  localparam logic RegSaturation = 1'b0;
  localparam logic RegBrightness = 1'b1;

  localparam logic [7:0] SaturationReset = 8'd220;
  localparam logic [7:0] BrightnessReset = 8'd200;

  localparam logic [7:0] SineRom [256] = '{
    8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149,
    8'd152, 8'd155, 8'd158, 8'd162, 8'd165, 8'd167, 8'd170, 8'd173,
    8'd176, 8'd179, 8'd182, 8'd185, 8'd188, 8'd190, 8'd193, 8'd196,
    8'd198, 8'd201, 8'd203, 8'd206, 8'd208, 8'd211, 8'd213, 8'd215,
    8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
    8'd234, 8'd235, 8'd237, 8'd239, 8'd240, 8'd241, 8'd243, 8'd244,
    8'd245, 8'd246, 8'd248, 8'd249, 8'd250, 8'd250, 8'd251, 8'd252,
    8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd254, 8'd253,
    8'd253, 8'd252, 8'd251, 8'd250, 8'd250, 8'd249, 8'd248, 8'd246,
    8'd245, 8'd244, 8'd243, 8'd241, 8'd240, 8'd239, 8'd237, 8'd235,
    8'd234, 8'd232, 8'd230, 8'd228, 8'd226, 8'd224, 8'd222, 8'd220,
    8'd218, 8'd215, 8'd213, 8'd211, 8'd208, 8'd206, 8'd203, 8'd201,
    8'd198, 8'd196, 8'd193, 8'd190, 8'd188, 8'd185, 8'd182, 8'd179,
    8'd176, 8'd173, 8'd170, 8'd167, 8'd165, 8'd162, 8'd158, 8'd155,
    8'd152, 8'd149, 8'd146, 8'd143, 8'd140, 8'd137, 8'd134, 8'd131,
    8'd128, 8'd124, 8'd121, 8'd118, 8'd115, 8'd112, 8'd109, 8'd106,
    8'd103, 8'd100, 8'd97,  8'd93,  8'd90,  8'd88,  8'd85,  8'd82,
    8'd79,  8'd76,  8'd73,  8'd70,  8'd67,  8'd65,  8'd62,  8'd59,
    8'd57,  8'd54,  8'd52,  8'd49,  8'd47,  8'd44,  8'd42,  8'd40,
    8'd37,  8'd35,  8'd33,  8'd31,  8'd29,  8'd27,  8'd25,  8'd23,
    8'd21,  8'd20,  8'd18,  8'd16,  8'd15,  8'd14,  8'd12,  8'd11,
    8'd10,  8'd9,   8'd7,   8'd6,   8'd5,   8'd5,   8'd4,   8'd3,
    8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd2,
    8'd2,   8'd3,   8'd4,   8'd5,   8'd5,   8'd6,   8'd7,   8'd9,
    8'd10,  8'd11,  8'd12,  8'd14,  8'd15,  8'd16,  8'd18,  8'd20,
    8'd21,  8'd23,  8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd35,
    8'd37,  8'd40,  8'd42,  8'd44,  8'd47,  8'd49,  8'd52,  8'd54,
    8'd57,  8'd59,  8'd62,  8'd65,  8'd67,  8'd70,  8'd73,  8'd76,
    8'd79,  8'd82,  8'd85,  8'd88,  8'd90,  8'd93,  8'd97,  8'd100,
    8'd103, 8'd106, 8'd109, 8'd112, 8'd115, 8'd118, 8'd121, 8'd124
  };

endpackage

### rtl/core/plasma_pixel_color_generator_unit.sv
// Plasma pixel color generator: eight-stage pipeline from block coordinate to RGB565.
//
//  channel   signals                                         direction
//  command   start, busy, block_x_i, block_y_i, frame_phase_i  in (busy out)
//  result    done_o, pixel_color_o                             out
//  config    psel, penable, pwrite, paddr, pwdata, prdata, pready  APB slave
//
// One transaction is accepted every cycle; busy stays low. Each result appears on
// done_o/pixel_color_o for one cycle, after passing the stage registers in order:
// index, sine ROM, sum, hue multiply, region split, saturation multiply, value
// multiply, pack. Reset clears all stage valid bits and loads saturation 220 and
// value 200. The receiver cannot stall the pipe.
module plasma_pixel_color_generator_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [4:0]                          block_x_i,
  input  logic [5:0]                          block_y_i,
  input  logic [7:0]                          frame_phase_i,
  output logic                                done_o,
  output logic [15:0]                         pixel_color_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ppcg_pkg::CfgAddrWidth-1:0]   paddr,
  input  logic [ppcg_pkg::CfgDataWidth-1:0]   pwdata,
  output logic [ppcg_pkg::CfgDataWidth-1:0]   prdata,
  output logic                                pready
);
  import ppcg_pkg::*;

  typedef enum logic [2:0] {
    RegionRed     = 3'd0,
    RegionYellow  = 3'd1,
    RegionGreen   = 3'd2,
    RegionCyan    = 3'd3,
    RegionBlue    = 3'd4,
    RegionMagenta = 3'd5
  } hue_region_e;

  // ---------------- configuration ----------------
  logic [7:0] sat_q, val_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= SaturationReset;
      val_q <= BrightnessReset;
    end else if (cfg_wr) begin
      if (paddr[2] == RegSaturation) sat_q <= pwdata[7:0];
      else                           val_q <= pwdata[7:0];
    end
  end

  always_comb begin
    if (paddr[2] == RegBrightness) prdata = {24'd0, val_q};
    else                           prdata = {24'd0, sat_q};
  end

  // ---------------- stage 1: sine indices ----------------
  logic [7:0]  idx_a_d, idx_b_d, idx_c_d, idx_d_d;
  logic [7:0]  idx_a_q, idx_b_q, idx_c_q, idx_d_q;
  logic [6:0]  xy_sum;
  logic [12:0] sq_sum;
  logic [7:0]  f2;
  logic        v1_q;

  always_comb begin
    f2      = {frame_phase_i[6:0], 1'b0};
    xy_sum  = {2'd0, block_x_i} + {1'b0, block_y_i};
    sq_sum  = {3'd0, 10'(block_x_i * block_x_i)} + {1'b0, 12'(block_y_i * block_y_i)};
    idx_a_d = {block_x_i, 3'd0} + frame_phase_i;
    idx_b_d = {block_y_i, 2'd0} + {1'b0, block_y_i, 1'b0} + f2;
    idx_c_d = {xy_sum[5:0], 2'd0} + frame_phase_i;
    idx_d_d = sq_sum[9:2] + frame_phase_i + f2;
  end

  always_ff @(posedge clk_i) begin
    idx_a_q <= idx_a_d;
    idx_b_q <= idx_b_d;
    idx_c_q <= idx_c_d;
    idx_d_q <= idx_d_d;
  end

  // ---------------- stage 2: sine lookups ----------------
  logic [7:0] sin_a_q, sin_b_q, sin_c_q, sin_d_q;
  logic       v2_q;

  always_ff @(posedge clk_i) begin
    sin_a_q <= SineRom[idx_a_q];
    sin_b_q <= SineRom[idx_b_q];
    sin_c_q <= SineRom[idx_c_q];
    sin_d_q <= SineRom[idx_d_q];
  end

  // ---------------- stage 3: sum ----------------
  logic [9:0] sum_d, sum_q;
  logic       v3_q;

  assign sum_d = {2'd0, sin_a_q} + {2'd0, sin_b_q} + {2'd0, sin_c_q} + {2'd0, sin_d_q};

  always_ff @(posedge clk_i) sum_q <= sum_d;

  // ---------------- stage 4: hue = sum*360/1024 ----------------
  logic [18:0] hue_prod;
  logic [8:0]  hue_q;
  logic        v4_q;

  assign hue_prod = {9'd0, sum_q} * 19'd360;

  always_ff @(posedge clk_i) hue_q <= hue_prod[18:10];

  // ---------------- stage 5: region and remainder ----------------
  hue_region_e region_d, region_q;
  logic [8:0]  rem_base;
  logic [5:0]  rem0;
  logic [9:0]  rem_prod;
  logic [7:0]  rem_d, rem_q;
  logic        v5_q;

  always_comb begin
    if (hue_q >= 9'd300) begin
      region_d = RegionMagenta;
      rem_base = 9'd300;
    end else if (hue_q >= 9'd240) begin
      region_d = RegionBlue;
      rem_base = 9'd240;
    end else if (hue_q >= 9'd180) begin
      region_d = RegionCyan;
      rem_base = 9'd180;
    end else if (hue_q >= 9'd120) begin
      region_d = RegionGreen;
      rem_base = 9'd120;
    end else if (hue_q >= 9'd60) begin
      region_d = RegionYellow;
      rem_base = 9'd60;
    end else begin
      region_d = RegionRed;
      rem_base = 9'd0;
    end
    rem0     = 6'(hue_q - rem_base);
    // 255/60 is exactly 17/4
    rem_prod = {rem0, 4'd0} + {4'd0, rem0};
    rem_d    = rem_prod[9:2];
  end

  always_ff @(posedge clk_i) begin
    region_q <= region_d;
    rem_q    <= rem_d;
  end

  // ---------------- stage 6: saturation products ----------------
  logic [15:0] sq_prod, st_prod;
  logic [7:0]  pf_q, qf_q, tf_q;
  hue_region_e region6_q;
  logic        v6_q;

  assign sq_prod = {8'd0, sat_q} * {8'd0, rem_q};
  assign st_prod = {8'd0, sat_q} * {8'd0, 8'd255 - rem_q};

  always_ff @(posedge clk_i) begin
    pf_q      <= 8'd255 - sat_q;
    qf_q      <= 8'd255 - sq_prod[15:8];
    tf_q      <= 8'd255 - st_prod[15:8];
    region6_q <= region_q;
  end

  // ---------------- stage 7: value products ----------------
  logic [15:0] p_prod, q_prod, t_prod;
  logic [7:0]  p_q, q_q, t_q;
  hue_region_e region7_q;
  logic        v7_q;

  assign p_prod = {8'd0, val_q} * {8'd0, pf_q};
  assign q_prod = {8'd0, val_q} * {8'd0, qf_q};
  assign t_prod = {8'd0, val_q} * {8'd0, tf_q};

  always_ff @(posedge clk_i) begin
    p_q       <= p_prod[15:8];
    q_q       <= q_prod[15:8];
    t_q       <= t_prod[15:8];
    region7_q <= region6_q;
  end

  // ---------------- stage 8: select and pack ----------------
  logic [7:0]  r_c, g_c, b_c;
  logic [15:0] color_d, color_q;
  logic        v8_q;

  always_comb begin
    case (region7_q)
      RegionRed:     begin r_c = val_q; g_c = t_q;   b_c = p_q;   end
      RegionYellow:  begin r_c = q_q;   g_c = val_q; b_c = p_q;   end
      RegionGreen:   begin r_c = p_q;   g_c = val_q; b_c = t_q;   end
      RegionCyan:    begin r_c = p_q;   g_c = q_q;   b_c = val_q; end
      RegionBlue:    begin r_c = t_q;   g_c = p_q;   b_c = val_q; end
      default:       begin r_c = val_q; g_c = p_q;   b_c = q_q;   end
    endcase
    // zero saturation: grey at the configured value
    if (sat_q == 8'd0) begin
      r_c = val_q;
      g_c = val_q;
      b_c = val_q;
    end
    color_d = {r_c[7:3], g_c[7:2], b_c[7:3]};
  end

  always_ff @(posedge clk_i) color_q <= color_d;

  // ---------------- valid chain ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else begin
      v1_q <= start & ~busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  assign done_o        = v8_q;
  assign pixel_color_o = color_q;

endmodule

### bench/tb_plasma_pixel_color_generator_unit.sv
// Self-checking bench for the plasma pixel color generator: directed table, then random phases.
module tb_plasma_pixel_color_generator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ppcg_pkg::*;

  localparam int PipeLatency   = 8;
  localparam int CycleLimit    = 100000;
  localparam int PhaseCount    = 8;
  localparam int ItemsPerPhase = 235;
  localparam int RowCount      = 22;

  typedef struct {
    logic [4:0]  x;
    logic [5:0]  y;
    logic [7:0]  f;
    logic [7:0]  sat;
    logic [7:0]  val;
    bit          known;
    logic [15:0] color;
  } stim_row_t;

  typedef struct {
    logic [15:0] color;
    bit          known;
    logic [15:0] typed;
    logic [4:0]  x;
    logic [5:0]  y;
    logic [7:0]  f;
  } pixel_expect_t;

  // x, y, frame, saturation, value, typed-in flag, typed-in color
  stim_row_t directed_rows [RowCount] = '{
    '{5'd0,  6'd0,  8'd0,   8'd220, 8'd200, 1'b1, 16'h1E39},
    '{5'd31, 6'd0,  8'd0,   8'd220, 8'd200, 1'b0, 16'h0000},
    '{5'd0,  6'd39, 8'd0,   8'd220, 8'd200, 1'b0, 16'h0000},
    '{5'd31, 6'd39, 8'd255, 8'd220, 8'd200, 1'b0, 16'h0000},
    '{5'd31, 6'd63, 8'd255, 8'd220, 8'd200, 1'b0, 16'h0000},
    '{5'd0,  6'd63, 8'd128, 8'd220, 8'd200, 1'b0, 16'h0000},
    '{5'd31, 6'd40, 8'd1,   8'd220, 8'd200, 1'b0, 16'h0000},
    '{5'd16, 6'd20, 8'd64,  8'd220, 8'd200, 1'b0, 16'h0000},
    '{5'd5,  6'd10, 8'd200, 8'd220, 8'd200, 1'b0, 16'h0000},
    '{5'd3,  6'd7,  8'd43,  8'd220, 8'd200, 1'b0, 16'h0000},
    '{5'd12, 6'd30, 8'd211, 8'd220, 8'd200, 1'b0, 16'h0000},
    '{5'd25, 6'd5,  8'd150, 8'd220, 8'd200, 1'b0, 16'h0000},
    '{5'd0,  6'd0,  8'd0,   8'd0,   8'd200, 1'b1, 16'hCE59},
    '{5'd31, 6'd63, 8'd255, 8'd0,   8'd200, 1'b1, 16'hCE59},
    '{5'd0,  6'd0,  8'd0,   8'd0,   8'd0,   1'b1, 16'h0000},
    '{5'd17, 6'd33, 8'd99,  8'd0,   8'd255, 1'b1, 16'hFFFF},
    '{5'd0,  6'd0,  8'd0,   8'd255, 8'd255, 1'b1, 16'h07FF},
    '{5'd31, 6'd63, 8'd255, 8'd255, 8'd255, 1'b0, 16'h0000},
    '{5'd10, 6'd20, 8'd30,  8'd255, 8'd0,   1'b1, 16'h0000},
    '{5'd7,  6'd3,  8'd170, 8'd1,   8'd255, 1'b0, 16'h0000},
    '{5'd22, 6'd11, 8'd85,  8'd128, 8'd64,  1'b0, 16'h0000},
    '{5'd9,  6'd41, 8'd17,  8'd128, 8'd64,  1'b0, 16'h0000}
  };

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [4:0]  block_x;
  logic [5:0]  block_y;
  logic [7:0]  frame_phase;
  logic        done;
  logic [15:0] pixel_color;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // typed-in color that travels with the current transaction
  bit          row_known;
  logic [15:0] row_color;

  logic [7:0]    model_saturation = SaturationReset;
  logic [7:0]    model_brightness = BrightnessReset;
  pixel_expect_t pending_pixels [$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;

  plasma_pixel_color_generator_unit dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start        (start),
    .busy         (busy),
    .block_x_i    (block_x),
    .block_y_i    (block_y),
    .frame_phase_i(frame_phase),
    .done_o       (done),
    .pixel_color_o(pixel_color),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [15:0] predict_rgb565(input logic [4:0] x, input logic [5:0] y,
                                                 input logic [7:0] f, input logic [7:0] sat,
                                                 input logic [7:0] val);
    int unsigned xi, yi, fi, s, v, sum, hue, region, rem, p, q, t, r, g, b;
    xi = 32'(x);
    yi = 32'(y);
    fi = 32'(f);
    s  = 32'(sat);
    v  = 32'(val);
    sum = 32'(SineRom[8'((xi * 8 + fi) & 255)]);
    sum += 32'(SineRom[8'((yi * 6 + fi * 2) & 255)]);
    sum += 32'(SineRom[8'(((xi + yi) * 4 + fi) & 255)]);
    sum += 32'(SineRom[8'(((xi * xi + yi * yi) / 4 + fi * 3) & 255)]);
    hue = sum * 360 / 1024;
    if (s == 0) begin
      r = v;
      g = v;
      b = v;
    end else begin
      region = hue / 60;
      rem = ((hue - region * 60) * 255 / 60) & 255;
      p = ((v * (255 - s)) >> 8) & 255;
      q = ((v * (255 - ((s * rem) >> 8))) >> 8) & 255;
      t = ((v * (255 - ((s * (255 - rem)) >> 8))) >> 8) & 255;
      case (region)
        0: begin r = v; g = t; b = p; end
        1: begin r = q; g = v; b = p; end
        2: begin r = p; g = v; b = t; end
        3: begin r = p; g = q; b = v; end
        4: begin r = t; g = p; b = v; end
        default: begin r = v; g = p; b = q; end
      endcase
    end
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // track config, record accepted transactions, check results
  always @(posedge clk) begin
    pixel_expect_t e;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("plasma_pixel_color_generator_unit verification failed");
      $finish;
    end else if (!rst_n) begin
      model_saturation = SaturationReset;
      model_brightness = BrightnessReset;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == RegSaturation) model_saturation = pwdata[7:0];
        else model_brightness = pwdata[7:0];
      end
      if (start && !busy) begin
        e.color = predict_rgb565(block_x, block_y, frame_phase, model_saturation,
                                 model_brightness);
        e.known = row_known;
        e.typed = row_color;
        e.x     = block_x;
        e.y     = block_y;
        e.f     = frame_phase;
        pending_pixels.push_back(e);
      end
      if (done) begin
        if (pending_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected pixel %h", pixel_color));
        end else begin
          e = pending_pixels.pop_front();
          if (pixel_color !== e.color)
            report_mismatch($sformatf("x=%0d y=%0d f=%0d: pixel %h, predicted %h",
                                      e.x, e.y, e.f, pixel_color, e.color));
          if (e.known && pixel_color !== e.typed)
            report_mismatch($sformatf("x=%0d y=%0d f=%0d: pixel %h, table says %h",
                                      e.x, e.y, e.f, pixel_color, e.typed));
        end
      end
    end
  end

  task automatic send_pixel(input logic [4:0] x, input logic [5:0] y, input logic [7:0] f,
                            input bit known, input logic [15:0] color);
    @(negedge clk);
    start       <= 1'b1;
    block_x     <= x;
    block_y     <= y;
    frame_phase <= f;
    row_known   <= known;
    row_color   <= color;
    do @(posedge clk); while (busy);
  endtask

  // drop start, with junk on the fields
  task automatic idle_burst(input int n);
    repeat (n) begin
      @(negedge clk);
      start       <= 1'b0;
      block_x     <= 5'($urandom_range(0, 31));
      block_y     <= 6'($urandom_range(0, 63));
      frame_phase <= 8'($urandom_range(0, 255));
    end
  endtask

  task automatic hold_start();
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic wait_for_results();
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (PipeLatency + 2) @(posedge clk);
  endtask

  task automatic apb_transfer(input bit is_write, input logic idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_register(input logic idx, input logic [7:0] want);
    logic [31:0] rdata;
    apb_transfer(1'b0, idx, 32'd0, rdata);
    if (rdata !== {24'd0, want})
      report_mismatch($sformatf("register %0d reads %h, want %h", idx, rdata, want));
  endtask

  // upper data bits carry junk; only the low byte lands
  task automatic write_register(input logic idx, input logic [7:0] value);
    logic [31:0] unused;
    logic [23:0] junk;
    junk = 24'($urandom);
    apb_transfer(1'b1, idx, {junk, value}, unused);
    check_register(idx, value);
  endtask

  initial begin
    logic [7:0] sat;
    logic [7:0] val;
    int         idle_pct;
    rst_n       = 1'b0;
    start       = 1'b0;
    block_x     = '0;
    block_y     = '0;
    frame_phase = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    row_known   = 1'b0;
    row_color   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    check_register(RegSaturation, SaturationReset);
    check_register(RegBrightness, BrightnessReset);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].sat != model_saturation ||
          directed_rows[i].val != model_brightness) begin
        hold_start();
        wait_for_results();
        if (directed_rows[i].sat != model_saturation)
          write_register(RegSaturation, directed_rows[i].sat);
        if (directed_rows[i].val != model_brightness)
          write_register(RegBrightness, directed_rows[i].val);
      end
      send_pixel(directed_rows[i].x, directed_rows[i].y, directed_rows[i].f,
                 directed_rows[i].known, directed_rows[i].color);
    end

    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0: begin sat = 8'd255; val = 8'd255; idle_pct = 20; end
        1: begin sat = 8'd0;   val = 8'd128; idle_pct = 35; end
        2: begin sat = 8'd1;   val = 8'd255; idle_pct = 0;  end
        3: begin sat = 8'd128; val = 8'd1;   idle_pct = 15; end
        7: begin sat = SaturationReset; val = BrightnessReset; idle_pct = 0; end
        default: begin
          sat = 8'($urandom_range(0, 255));
          val = 8'($urandom_range(0, 255));
          idle_pct = 10 * ph - 30;
        end
      endcase
      // drain the pipe before touching the registers
      hold_start();
      wait_for_results();
      write_register(RegSaturation, sat);
      write_register(RegBrightness, val);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
          idle_burst($urandom_range(1, 6));
        send_pixel(5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
                   8'($urandom_range(0, 255)), 1'b0, 16'h0000);
      end
    end

    hold_start();
    wait_for_results();
    if (mismatch_count == 0) begin
      $display("plasma_pixel_color_generator_unit verification clean");
    end else begin
      $display("plasma_pixel_color_generator_unit verification failed");
    end
    $finish;
  end

endmodule
